FILE: design/nmea_pkg.sv
// Shared types, codes and lookup functions for the NMEA GGA/RMC field extractor.
`default_nettype none

package nmea_pkg;

  localparam int LINE_LENGTH_DEF = 82;
  localparam int LINE_POS_W      = 7;
  localparam int CHAR_IDX_W      = 4;
  localparam int COMMA_W         = 4;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;

  typedef enum logic [1:0] {
    RK_CHAR     = 2'd0,
    RK_END      = 2'd1,
    RK_OVERFLOW = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    SK_NONE = 2'd0,
    SK_GGA  = 2'd1,
    SK_RMC  = 2'd2
  } sentence_kind_t;

  typedef enum logic [2:0] {
    FLD_TIME  = 3'd0,
    FLD_LAT   = 3'd1,
    FLD_LON   = 3'd2,
    FLD_FIX   = 3'd3,
    FLD_ALT   = 3'd4,
    FLD_SPEED = 3'd5,
    FLD_DATE  = 3'd6,
    FLD_NONE  = 3'd7
  } field_id_t;

  // Header walk: expecting G, talker letter, then three sentence id letters.
  typedef enum logic [2:0] {
    HDR_IDLE   = 3'd0,
    HDR_G      = 3'd1,
    HDR_TALKER = 3'd2,
    HDR_ID0    = 3'd3,
    HDR_ID1    = 3'd4,
    HDR_ID2    = 3'd5,
    HDR_DONE   = 3'd6,
    HDR_FAIL   = 3'd7
  } hdr_state_t;

  function automatic field_id_t wanted_field(input sentence_kind_t kind,
                                             input logic [COMMA_W-1:0] commas);
    field_id_t f;
    f = FLD_NONE;
    if (kind == SK_GGA) begin
      case (commas)
        4'd1:    f = FLD_TIME;
        4'd2:    f = FLD_LAT;
        4'd4:    f = FLD_LON;
        4'd6:    f = FLD_FIX;
        4'd9:    f = FLD_ALT;
        default: f = FLD_NONE;
      endcase
    end else if (kind == SK_RMC) begin
      case (commas)
        4'd7:    f = FLD_SPEED;
        4'd9:    f = FLD_DATE;
        default: f = FLD_NONE;
      endcase
    end
    return f;
  endfunction

  function automatic logic [CHAR_IDX_W-1:0] field_width(input field_id_t f);
    logic [CHAR_IDX_W-1:0] w;
    case (f)
      FLD_TIME:  w = 4'd10;
      FLD_LAT:   w = 4'd9;
      FLD_LON:   w = 4'd10;
      FLD_FIX:   w = 4'd1;
      FLD_ALT:   w = 4'd5;
      FLD_SPEED: w = 4'd5;
      FLD_DATE:  w = 4'd6;
      default:   w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/nmea_gga_rmc_field_extractor.sv
// NMEA GGA/RMC field extractor: byte stream in, field characters and sentence marks out.
//
// Input channel (in_*): one received NMEA byte per word. Output channel (out_*):
// one word per wanted field character, one per sentence end ('*') and one per
// abandoned over-long line. Bytes that produce nothing simply vanish.
// Field characters are tentative; the consumer commits them when the end word
// arrives with a recognized sentence kind (GGA or RMC) and drops them when the
// kind is unrecognized or an overflow word arrives.
// Path: a byte is registered in the input register on acceptance, then
// evaluated against the parser state; its result word is registered in the
// result register that drives out_tvalid. Throughput: one byte per cycle
// while the output is not stalled; the parser state is updated as each byte
// moves from the input register to the result register.
// Stall: while out_tvalid is high and out_tready low, the held byte waits in
// the input register and in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous): both registers empty, no sentence open.
// The checksum and line terminators after '*' are ignored.
`default_nettype none

module nmea_gga_rmc_field_extractor
  import nmea_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF  // 16..127 bytes, '$' included
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // [2:0] field_id, [6:3] char_index,
                                       // [14:7] char_value, [16:15] sentence_kind, rest 0
  output      logic [1:0]  out_tuser   // [1:0] result_kind
);

  localparam logic [LINE_POS_W-1:0] LINE_LEN_C = LINE_POS_W'(LINE_LENGTH);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // parser state
  logic                  in_sent_r,  in_sent_nxt;
  hdr_state_t            hdr_r,      hdr_nxt;
  sentence_kind_t        kind_r,     kind_nxt;
  logic [COMMA_W-1:0]    comma_r,    comma_nxt;
  logic [CHAR_IDX_W-1:0] fcc_r,      fcc_nxt;
  logic [LINE_POS_W-1:0] line_pos_r, line_pos_nxt;

  // result register
  logic                  out_vld_r,   out_vld_nxt;
  result_kind_t          rkind_r,     rkind_nxt;
  field_id_t             fid_r,       fid_nxt;
  logic [CHAR_IDX_W-1:0] cidx_r,      cidx_nxt;
  logic [7:0]            cval_r,      cval_nxt;
  sentence_kind_t        skind_r,     skind_nxt;

  logic      adv;
  logic      is_dollar, is_star, is_comma, overflow, body, emit;
  field_id_t fld;

  // The staged byte moves on when the result register is free or draining.
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  assign is_dollar = (in_byte_r == CH_DOLLAR);
  assign is_star   = (in_byte_r == CH_STAR);
  assign is_comma  = (in_byte_r == CH_COMMA);
  assign overflow  = (line_pos_r >= LINE_LEN_C);
  // ordinary byte inside an open sentence that still fits the line
  assign body      = in_sent_r && !is_dollar && !is_star && !overflow;
  assign fld       = wanted_field(kind_r, comma_r);
  assign emit      = body && (hdr_r == HDR_DONE) && !is_comma && (fld != FLD_NONE)
                     && (fcc_r < field_width(fld));

  // next parser state
  always_comb begin
    in_sent_nxt  = in_sent_r;
    hdr_nxt      = hdr_r;
    kind_nxt     = kind_r;
    comma_nxt    = comma_r;
    fcc_nxt      = fcc_r;
    line_pos_nxt = line_pos_r;
    if (is_dollar) begin
      in_sent_nxt  = 1'b1;
      hdr_nxt      = HDR_G;
      kind_nxt     = SK_NONE;
      comma_nxt    = '0;
      fcc_nxt      = '0;
      line_pos_nxt = LINE_POS_W'(1);
    end else if (in_sent_r && (is_star || overflow)) begin
      in_sent_nxt = 1'b0;
      hdr_nxt     = HDR_IDLE;
    end else if (body) begin
      line_pos_nxt = line_pos_r + LINE_POS_W'(1);
      unique case (hdr_r)
        HDR_G: begin
          hdr_nxt = (in_byte_r == CH_G) ? HDR_TALKER : HDR_FAIL;
        end
        HDR_TALKER: begin
          hdr_nxt = (in_byte_r == CH_P || in_byte_r == CH_L ||
                     in_byte_r == CH_S || in_byte_r == CH_N) ? HDR_ID0 : HDR_FAIL;
        end
        HDR_ID0: begin
          if (in_byte_r == CH_G) begin
            hdr_nxt  = HDR_ID1;
            kind_nxt = SK_GGA;
          end else if (in_byte_r == CH_R) begin
            hdr_nxt  = HDR_ID1;
            kind_nxt = SK_RMC;
          end else begin
            hdr_nxt  = HDR_FAIL;
          end
        end
        HDR_ID1: begin
          hdr_nxt = (in_byte_r == ((kind_r == SK_GGA) ? CH_G : CH_M)) ? HDR_ID2 : HDR_FAIL;
        end
        HDR_ID2: begin
          hdr_nxt = (in_byte_r == ((kind_r == SK_GGA) ? CH_A : CH_C)) ? HDR_DONE : HDR_FAIL;
        end
        HDR_DONE: begin
          if (is_comma) begin
            if (comma_r != {COMMA_W{1'b1}}) comma_nxt = comma_r + COMMA_W'(1);
            fcc_nxt = '0;
          end else if (emit) begin
            fcc_nxt = fcc_r + CHAR_IDX_W'(1);
          end
        end
        default: ;  // idle or rejected header: only the line count moves
      endcase
      // a rejected header forgets its candidate kind
      if ((hdr_r != HDR_DONE) && (hdr_r != HDR_FAIL) && (hdr_r != HDR_IDLE) &&
          (hdr_nxt == HDR_FAIL)) begin
        kind_nxt = SK_NONE;
      end
    end
  end

  // result word
  always_comb begin
    out_vld_nxt = 1'b0;
    rkind_nxt   = RK_CHAR;
    fid_nxt     = FLD_TIME;
    cidx_nxt    = '0;
    cval_nxt    = '0;
    skind_nxt   = SK_NONE;
    if (!is_dollar && in_sent_r) begin
      if (is_star) begin
        out_vld_nxt = 1'b1;
        rkind_nxt   = RK_END;
        skind_nxt   = (hdr_r == HDR_DONE) ? kind_r : SK_NONE;
      end else if (overflow) begin
        out_vld_nxt = 1'b1;
        rkind_nxt   = RK_OVERFLOW;
      end else if (emit) begin
        out_vld_nxt = 1'b1;
        fid_nxt     = fld;
        cidx_nxt    = fcc_r;
        cval_nxt    = in_byte_r;
        skind_nxt   = kind_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      in_sent_r  <= 1'b0;
      hdr_r      <= HDR_IDLE;
      kind_r     <= SK_NONE;
      comma_r    <= '0;
      fcc_r      <= '0;
      line_pos_r <= '0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (adv) begin
        out_vld_r  <= out_vld_nxt;
        in_sent_r  <= in_sent_nxt;
        hdr_r      <= hdr_nxt;
        kind_r     <= kind_nxt;
        comma_r    <= comma_nxt;
        fcc_r      <= fcc_nxt;
        line_pos_r <= line_pos_nxt;
      end else if (out_tready) begin
        out_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
    if (adv) begin
      rkind_r <= rkind_nxt;
      fid_r   <= fid_nxt;
      cidx_r  <= cidx_nxt;
      cval_r  <= cval_nxt;
      skind_r <= skind_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, skind_r, cval_r, cidx_r, fid_r};
  assign out_tuser  = rkind_r;

endmodule

`default_nettype wire
